@@ design/twwt_pkg.sv @@
package twwt_pkg;

   localparam int PEND_W      = 6;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = 5;
   localparam int TASK_W      = 16;
   localparam int TOKEN_W     = 32;
   localparam int TIME_W      = 48;

   localparam logic [PEND_W-1:0]  PENDING_MAX = 6'd63;
   localparam logic [CNT_W-1:0]   RESULT_CAP  = 5'd16;

   typedef enum logic [2:0] {
      FN_REGISTER = 3'd0,
      FN_TOKEN_WAIT = 3'd1,
      FN_DEADLINE_WAIT = 3'd2,
      FN_SIGNAL = 3'd3,
      FN_TICK = 3'd4,
      FN_ALLOC = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      KIND_DONE = 2'd0,
      KIND_RESUMED = 2'd1,
      KIND_TOKEN = 2'd2,
      KIND_REJECTED = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_FLUSH
   } state_type;

endpackage

@@ design/task_wait_wakeup_table_top.sv @@
// task wait / wake-up table
// req channel: one operation per item, func in req_tuser, operands in req_tdata.
// rsp channel: result items; kind in rsp_tuser, rsp_tlast marks the final result
// of an operation. register, wait, allocate and unused codes give one result.
// signal and tick give one result per resumed task (at most 16) or a single
// done result when nothing resumes.
// register, wait and allocate go from the request registers into the result register.
// signal and tick walk every wait slot through the wait memory, with one read
// state and one evaluate state per slot.
// one operation is in flight at a time; req_tready is high only when idle.
// the result register holds an item until rsp_tready; a stalled receiver
// stops the walk at the next resume that must be sent.
// reset clears the task and wait valid bits and sets the token counter to 1;
// no clearing pass is needed.
module task_wait_wakeup_table_top import twwt_pkg::*; #(
   parameter int TASK_SLOTS = 16,
   parameter int WAIT_SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // task_req[15:0], token[47:16], time_value[95:48]
   input  logic [2:0]  req_tuser,   // func[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // resumed_task[15:0], new_token[47:16]
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast
);

   localparam int TW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int WW = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
   localparam int ENTRY_W = 1 + TW + TIME_W;
   localparam logic [WW-1:0] LAST_SLOT = WW'(WAIT_SLOTS - 1);

   state_type state_ff, state_in;

   logic [2:0]         func_ff;
   logic [TASK_W-1:0]  id_ff;
   logic [TOKEN_W-1:0] tok_ff;
   logic [TIME_W-1:0]  tv_ff;

   logic                task_used_ff [TASK_SLOTS];
   logic [TASK_W-1:0]   task_ident_ff [TASK_SLOTS];
   logic [PEND_W-1:0]   task_pend_ff [TASK_SLOTS];
   logic [WAIT_SLOTS-1:0] wait_used_ff;
   logic [TOKEN_W-1:0]  counter_ff;

   logic [WW-1:0]       scan_ff;
   logic [CNT_W-1:0]    n_ff;
   logic                held_ff;
   logic [TASK_W-1:0]   held_id_ff;

   logic                rsp_valid_ff;
   kind_type            rsp_kind_ff;
   logic [TASK_W-1:0]   rsp_task_ff;
   logic [TOKEN_W-1:0]  rsp_tok_ff;
   logic                rsp_last_ff;

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // associative lookup over the task table and search for free task and wait slots
   logic          id_hit;
   logic [TW-1:0] id_idx;
   logic          task_free;
   logic [TW-1:0] task_free_idx;
   logic          wait_free;
   logic [WW-1:0] wait_free_idx;

   always_comb begin
      id_hit = 1'b0;
      id_idx = '0;
      task_free = 1'b0;
      task_free_idx = '0;
      for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
         if (task_used_ff[i] && task_ident_ff[i] == id_ff) begin
            id_hit = 1'b1;
            id_idx = TW'(i);
         end
         if (!task_used_ff[i]) begin
            task_free = 1'b1;
            task_free_idx = TW'(i);
         end
      end
      wait_free = 1'b0;
      wait_free_idx = '0;
      for (int w = WAIT_SLOTS - 1; w >= 0; w--) begin
         if (!wait_used_ff[w]) begin
            wait_free = 1'b1;
            wait_free_idx = WW'(w);
         end
      end
   end

   // wait memory
   logic                wr_en;
   logic [ENTRY_W-1:0]  wr_data;
   logic [ENTRY_W-1:0]  rd_data;
   logic                e_is_token;
   logic [TW-1:0]       e_owner;
   logic [TIME_W-1:0]   e_value;

   assign wr_data = {(func_ff == FN_TOKEN_WAIT), id_idx,
                     (func_ff == FN_TOKEN_WAIT) ? {16'd0, tok_ff} : tv_ff};
   assign {e_is_token, e_owner, e_value} = rd_data;

   twwt_wait_ram #(.DEPTH(WAIT_SLOTS), .DATA_W(ENTRY_W)) u_wait_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wait_free_idx),
      .wr_data(wr_data),
      .rd_addr(scan_ff),
      .rd_data(rd_data)
   );

   // evaluation of the slot just read
   logic              want_token;
   logic              hit;
   logic              own_ok;
   logic [PEND_W-1:0] pend_cur;
   logic [PEND_W-1:0] pend_dec;
   logic              resume;
   logic              report;
   logic              stall;

   always_comb begin
      want_token = (func_ff == FN_SIGNAL);
      hit = wait_used_ff[scan_ff] && (e_is_token == want_token) &&
            (want_token ? (e_value == {16'd0, tok_ff}) : (e_value < tv_ff));
      own_ok = ({1'b0, e_owner} < (TW+1)'(TASK_SLOTS)) && task_used_ff[e_owner];
      pend_cur = own_ok ? task_pend_ff[e_owner] : '0;
      pend_dec = (pend_cur != '0) ? pend_cur - 1'b1 : '0;
      resume = hit && own_ok && (pend_dec == '0);
      report = resume && (n_ff < RESULT_CAP);
      stall = report && held_ff && !out_free;
   end

   logic wait_ok;
   assign wait_ok = id_hit && (task_pend_ff[id_idx] < PENDING_MAX) && wait_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == FN_SIGNAL || req_tuser == FN_TICK) begin
                  state_in = ST_SCAN_RD;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: if (out_free) state_in = ST_IDLE;
         ST_SCAN_RD: state_in = ST_SCAN_EV;
         ST_SCAN_EV: begin
            if (!stall) state_in = (scan_ff == LAST_SLOT) ? ST_FLUSH : ST_SCAN_RD;
         end
         ST_FLUSH: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the controller
   logic               out_load;
   kind_type           out_kind;
   logic [TASK_W-1:0]  out_task;
   logic [TOKEN_W-1:0] out_tok;
   logic               out_last;
   logic               do_reg;
   logic               do_wait;
   logic               do_alloc;
   logic               do_remove;

   always_comb begin
      out_load = 1'b0;
      out_kind = KIND_DONE;
      out_task = '0;
      out_tok = '0;
      out_last = 1'b1;
      do_reg = 1'b0;
      do_wait = 1'b0;
      do_alloc = 1'b0;
      do_remove = 1'b0;
      wr_en = 1'b0;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_EXEC: begin
            if (out_free) begin
               out_load = 1'b1;
               case (func_ff)
                  FN_REGISTER: begin
                     if (id_hit || !task_free) begin
                        out_kind = KIND_REJECTED;
                     end else begin
                        do_reg = 1'b1;
                     end
                  end
                  FN_TOKEN_WAIT, FN_DEADLINE_WAIT: begin
                     if (wait_ok) begin
                        do_wait = 1'b1;
                        wr_en = 1'b1;
                     end else begin
                        out_kind = KIND_REJECTED;
                     end
                  end
                  FN_ALLOC: begin
                     do_alloc = 1'b1;
                     out_kind = KIND_TOKEN;
                     out_tok = counter_ff;
                  end
                  default: out_kind = KIND_DONE;
               endcase
            end
         end
         ST_SCAN_EV: begin
            if (hit && !stall) begin
               do_remove = 1'b1;
               if (report && held_ff) begin
                  out_load = 1'b1;
                  out_kind = KIND_RESUMED;
                  out_task = held_id_ff;
                  out_last = 1'b0;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_load = 1'b1;
               out_kind = held_ff ? KIND_RESUMED : KIND_DONE;
               out_task = held_ff ? held_id_ff : '0;
            end
         end
         default: out_load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_used_ff <= '0;
         counter_ff <= 32'd1;
         rsp_valid_ff <= 1'b0;
         held_ff <= 1'b0;
         n_ff <= '0;
         scan_ff <= '0;
         for (int i = 0; i < TASK_SLOTS; i++) begin
            task_used_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_IDLE && req_tvalid) begin
            scan_ff <= '0;
            n_ff <= '0;
            held_ff <= 1'b0;
         end
         if (state_ff == ST_SCAN_EV && !stall && scan_ff != LAST_SLOT) begin
            scan_ff <= scan_ff + 1'b1;
         end
         if (do_reg) begin
            task_used_ff[task_free_idx] <= 1'b1;
         end
         if (do_wait) begin
            wait_used_ff[wait_free_idx] <= 1'b1;
         end
         if (do_alloc) begin
            counter_ff <= counter_ff + 1'b1;
         end
         if (do_remove) begin
            wait_used_ff[scan_ff] <= 1'b0;
            if (resume) begin
               task_used_ff[e_owner] <= 1'b0;
            end
            if (report) begin
               held_ff <= 1'b1;
               n_ff <= n_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         func_ff <= req_tuser;
         id_ff <= req_tdata[15:0];
         tok_ff <= req_tdata[47:16];
         tv_ff <= req_tdata[95:48];
      end
      if (do_reg) begin
         task_ident_ff[task_free_idx] <= id_ff;
         task_pend_ff[task_free_idx] <= '0;
      end
      if (do_wait) begin
         task_pend_ff[id_idx] <= task_pend_ff[id_idx] + 1'b1;
      end
      if (do_remove && own_ok) begin
         task_pend_ff[e_owner] <= pend_dec;
      end
      if (do_remove && report) begin
         held_id_ff <= task_ident_ff[e_owner];
      end
      if (out_load) begin
         rsp_kind_ff <= out_kind;
         rsp_task_ff <= out_task;
         rsp_tok_ff <= out_tok;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_tok_ff, rsp_task_ff};
   assign rsp_tuser = rsp_kind_ff;
   assign rsp_tlast = rsp_last_ff;

   a_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= RESULT_CAP) else $error("result count above cap");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_tready)) else $error("result overwritten");

   a_held_last: assert property (@(posedge clock) disable iff (reset)
      (out_load && !out_last) |-> (state_ff == ST_SCAN_EV && held_ff))
      else $error("non-final result outside a walk");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_EV) |-> (scan_ff <= LAST_SLOT)) else $error("scan out of range");

endmodule

@@ design/twwt_wait_ram.sv @@
module twwt_wait_ram import twwt_pkg::*; #(
   parameter int DEPTH  = 32,
   parameter int DATA_W = 53
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ dv/task_wait_wakeup_table_top_test.sv @@
`timescale 1ns / 100ps

module task_wait_wakeup_table_top_test;
   import twwt_pkg::*;

   localparam int NSLOT = 16;
   localparam int NWAIT = 32;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] ident;
      logic [31:0] tok;
      logic        last;
   } wake_result_t;

   typedef struct {
      logic [2:0]  fn;
      logic [15:0] ident;
      logic [31:0] tok;
      logic [47:0] tv;
      logic        typed;
      logic [1:0]  kind;
      logic [31:0] rtok;
   } op_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // predictor state
   bit          tsk_used [NSLOT];
   logic [15:0] tsk_id [NSLOT];
   int unsigned tsk_pend [NSLOT];
   bit          wt_used [NWAIT];
   bit          wt_tok [NWAIT];
   int unsigned wt_owner [NWAIT];
   logic [47:0] wt_val [NWAIT];
   logic [31:0] tok_counter;

   wake_result_t wake_q[$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   op_row_t     rows[$];

   task_wait_wakeup_table_top dut (.*);

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic void push(input logic [1:0] k, input logic [15:0] id,
                                input logic [31:0] t, input logic l);
      wake_result_t r;
      r.kind = k; r.ident = id; r.tok = t; r.last = l;
      wake_q.push_back(r);
   endfunction

   function automatic int lookup_task(input logic [15:0] id);
      for (int i = 0; i < NSLOT; i++)
         if (tsk_used[i] && tsk_id[i] == id) return i;
      return -1;
   endfunction

   function automatic void predict_wait(input logic [15:0] id, input bit is_tok,
                                        input logic [47:0] v);
      int t;
      int w;
      t = lookup_task(id);
      w = -1;
      if (t < 0 || tsk_pend[t] >= 63) begin
         push(KIND_REJECTED, '0, '0, 1'b1);
         return;
      end
      for (int i = 0; i < NWAIT; i++)
         if (!wt_used[i]) begin
            w = i;
            break;
         end
      if (w < 0) begin
         push(KIND_REJECTED, '0, '0, 1'b1);
         return;
      end
      wt_used[w] = 1; wt_tok[w] = is_tok; wt_owner[w] = t; wt_val[w] = v;
      tsk_pend[t]++;
      push(KIND_DONE, '0, '0, 1'b1);
   endfunction

   function automatic void predict_sweep(input bit is_tok, input logic [47:0] key);
      int n;
      int t;
      bit hit;
      n = 0;
      for (int w = 0; w < NWAIT; w++) begin
         if (!wt_used[w] || wt_tok[w] != is_tok) continue;
         hit = is_tok ? (wt_val[w] == key) : (wt_val[w] < key);
         if (!hit) continue;
         wt_used[w] = 0;
         t = wt_owner[w];
         if (!tsk_used[t]) continue;
         if (tsk_pend[t] > 0) tsk_pend[t]--;
         if (tsk_pend[t] == 0) begin
            tsk_used[t] = 0;
            if (n < MAX_RESULTS) begin
               push(KIND_RESUMED, tsk_id[t], '0, 1'b0);
               n++;
            end
         end
      end
      if (n == 0) push(KIND_DONE, '0, '0, 1'b1);
      else wake_q[$].last = 1'b1;
   endfunction

   function automatic void predict_op(input logic [2:0] fn, input logic [15:0] id,
                                      input logic [31:0] tok, input logic [47:0] tv);
      int s;
      s = -1;
      case (fn)
         FN_REGISTER: begin
            if (lookup_task(id) >= 0) begin
               push(KIND_REJECTED, '0, '0, 1'b1);
               return;
            end
            for (int i = 0; i < NSLOT; i++)
               if (!tsk_used[i]) begin
                  s = i;
                  break;
               end
            if (s < 0) begin
               push(KIND_REJECTED, '0, '0, 1'b1);
               return;
            end
            tsk_used[s] = 1; tsk_id[s] = id; tsk_pend[s] = 0;
            push(KIND_DONE, '0, '0, 1'b1);
         end
         FN_TOKEN_WAIT:    predict_wait(id, 1'b1, {16'd0, tok});
         FN_DEADLINE_WAIT: predict_wait(id, 1'b0, tv);
         FN_SIGNAL:        predict_sweep(1'b1, {16'd0, tok});
         FN_TICK:          predict_sweep(1'b0, tv);
         FN_ALLOC: begin
            push(KIND_TOKEN, '0, tok_counter, 1'b1);
            tok_counter++;
         end
         default:          push(KIND_DONE, '0, '0, 1'b1);
      endcase
   endfunction

   // tvalid drops only for idle cycles, so each time step sees one assignment
   task automatic send_op(input logic [2:0] fn, input logic [15:0] id,
                          input logic [31:0] tok, input logic [47:0] tv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= fn;
      req_tdata <= {tv, tok, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_op(fn, id, tok, tv);
   endtask

   // receiver with random stalls; checks each result item against the queue
   always @(posedge clock) begin
      wake_result_t want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (wake_q.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata, '0);
            end else begin
               want = wake_q.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch("kind", 48'(rsp_tuser), 48'(want.kind));
               if (rsp_tdata[15:0] !== want.ident)
                  report_mismatch("resumed_task", 48'(rsp_tdata[15:0]), 48'(want.ident));
               if (rsp_tdata[47:16] !== want.tok)
                  report_mismatch("new_token", 48'(rsp_tdata[47:16]), 48'(want.tok));
               if (rsp_tlast !== want.last)
                  report_mismatch("last", 48'(rsp_tlast), 48'(want.last));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic op_row_t mk(input logic [2:0] fn, input logic [15:0] id,
                                  input logic [31:0] tok, input logic [47:0] tv,
                                  input bit typed = 0, input logic [1:0] k = KIND_DONE,
                                  input logic [31:0] rt = '0);
      op_row_t r;
      r.fn = fn; r.ident = id; r.tok = tok; r.tv = tv;
      r.typed = typed; r.kind = k; r.rtok = rt;
      return r;
   endfunction

   logic [15:0] pool [8];

   initial begin
      int n;
      int ph;
      int pick;
      logic [2:0] fn;
      logic [15:0] id;
      logic [31:0] tok;
      logic [47:0] tv;
      wake_result_t e;
      for (int i = 0; i < NSLOT; i++) tsk_used[i] = 0;
      for (int i = 0; i < NWAIT; i++) wt_used[i] = 0;
      tok_counter = 32'd1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      rows.push_back(mk(FN_ALLOC, 16'h0, 32'h0, 48'h0, 1, KIND_TOKEN, 32'd1));
      rows.push_back(mk(FN_TOKEN_WAIT, 16'h1234, 32'h5, 48'h0, 1, KIND_REJECTED));
      rows.push_back(mk(FN_SIGNAL, 16'h0, 32'h5, 48'h0, 1, KIND_DONE));
      rows.push_back(mk(FN_REGISTER, 16'hffff, 32'h0, 48'h0, 1, KIND_DONE));
      rows.push_back(mk(FN_REGISTER, 16'hffff, 32'h0, 48'h0, 1, KIND_REJECTED));
      rows.push_back(mk(FN_REGISTER, 16'h0000, 32'h0, 48'h0, 1, KIND_DONE));
      rows.push_back(mk(FN_TOKEN_WAIT, 16'hffff, 32'hffffffff, 48'h0));
      rows.push_back(mk(FN_DEADLINE_WAIT, 16'hffff, 32'h0, 48'hffffffffffff));
      rows.push_back(mk(FN_DEADLINE_WAIT, 16'h0000, 32'h0, 48'h0));
      rows.push_back(mk(FN_TICK, 16'h0, 32'h0, 48'h0));
      rows.push_back(mk(FN_TICK, 16'h0, 32'h0, 48'h1));
      rows.push_back(mk(FN_SIGNAL, 16'h0, 32'hffffffff, 48'h0));
      rows.push_back(mk(FN_TICK, 16'h0, 32'h0, 48'hffffffffffff));
      rows.push_back(mk(FN_TICK, 16'h0, 32'h0, 48'hffffffffffff));
      rows.push_back(mk(3'd6, 16'hffff, 32'hffffffff, 48'hffffffffffff, 1, KIND_DONE));
      rows.push_back(mk(3'd7, 16'h0, 32'h0, 48'h0, 1, KIND_DONE));
      rows.push_back(mk(FN_ALLOC, 16'h0, 32'h0, 48'h0, 1, KIND_TOKEN, 32'd2));
      foreach (rows[i]) begin
         send_op(rows[i].fn, rows[i].ident, rows[i].tok, rows[i].tv);
         if (rows[i].typed) begin
            e = wake_q[$];
            if (e.kind !== rows[i].kind || e.tok !== rows[i].rtok)
               report_mismatch("table row", 48'(e.kind), 48'(rows[i].kind));
         end
      end

      // fill the task table and overflow it; fill and overflow the wait table
      for (int i = 0; i < 17; i++) send_op(FN_REGISTER, 16'(16'h100 + i), '0, '0);
      for (int i = 0; i < 66; i++) send_op(FN_TOKEN_WAIT, 16'h100, 32'h77, '0);
      send_op(FN_SIGNAL, '0, 32'h77, '0);
      for (int i = 0; i < 34; i++)
         send_op(FN_DEADLINE_WAIT, 16'(16'h101 + (i % 15)), '0, 48'd9);
      // fourteen resumes in one tick, fewer than the cap of sixteen
      send_op(FN_TICK, '0, '0, 48'd10);
      send_op(FN_TICK, '0, '0, 48'hffffffffffff);
      tok_counter = tok_counter; // counter near wrap is not reachable; rely on random alloc

      // random part, idling phases of 90 items each
      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 17 : 71) : 0;
         recv_stall_pct = (ph == 2) ? 71 : ((ph == 3) ? 17 : 0);
         for (int i = 0; i < 8; i++) pool[i] = 16'($urandom);
         pool[0] = 16'hffff; pool[1] = 16'h0000;
         for (n = 0; n < 90; n++) begin
            pick = $urandom_range(99);
            id = pool[$urandom_range(7)];
            tok = $urandom_range(7);
            tv = 48'($urandom_range(63));
            if ($urandom_range(9) == 0) begin
               id = 16'($urandom);
               tok = $urandom;
               tv = {16'($urandom), $urandom};
            end
            if (pick < 15) fn = FN_REGISTER;
            else if (pick < 45) fn = FN_TOKEN_WAIT;
            else if (pick < 70) fn = FN_DEADLINE_WAIT;
            else if (pick < 82) fn = FN_SIGNAL;
            else if (pick < 92) fn = FN_TICK;
            else if (pick < 98) fn = FN_ALLOC;
            else fn = 3'($urandom_range(7, 6));
            send_op(fn, id, tok, tv);
         end
      end
      req_tvalid <= 1'b0;

      n = 0;
      while (wake_q.size() != 0 && n < IDLE_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (100) @(posedge clock);
      if (errors == 0 && wake_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
